// File: rtl/core/tss_pkg.sv
// ----------------------------------------------------------------------------
// Textured span shader package
// Shared types, codes and default sizes of the span shader.
// ----------------------------------------------------------------------------
package tss_pkg;

  // Default sizes for the top level parameters.
  localparam int unsigned MaxScreenDef = 1024;
  localparam int unsigned TexDepthDef  = 65536;

  // Width of the configuration write data.
  localparam int unsigned CfgDataW = 11;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_TEXEL = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SCREEN_W = 2'd0,
    CFG_SCREEN_H = 2'd1,
    CFG_TEX_W    = 2'd2,
    CFG_TEX_H    = 2'd3
  } cfg_e;

  // Input word.
  typedef struct packed {
    op_e                op;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [15:0]        tex_s;
    logic [15:0]        tex_t;
    logic [15:0]        texel_index;
    logic [23:0]        texel_value;
  } in_item_t;

  // Output word.
  typedef struct packed {
    logic [19:0] pixel_index;
    logic [23:0] pixel_color;
    logic        span_last;
  } out_item_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_LERP,
    S_MIX,
    S_TEXC,
    S_ADDR,
    S_READ,
    S_PROD,
    S_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tex_wr;
    logic ld_left;
    logic ld_right;
    logic div_load;
    logic div_step;
    logic lerp;
    logic mix;
    logic texc;
    logic addr;
    logic read;
    logic prod;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic span_active;
    logic div_done;
  } dp_status_t;

endpackage

// File: rtl/core/tss_datapath.sv
// ----------------------------------------------------------------------------
// Textured span shader datapath
// Configuration and span registers, weight divider, interpolation, texel
// store and color modulation, each step enabled by the controller.
// ----------------------------------------------------------------------------
module tss_datapath #(
  parameter int unsigned MAX_SCREEN = tss_pkg::MaxScreenDef,
  parameter int unsigned TEX_DEPTH  = tss_pkg::TexDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [tss_pkg::CfgDataW-1:0]   cfg_data_i,
  input  tss_pkg::in_item_t              in_data_i,
  input  tss_pkg::dp_cmd_t               cmd_i,
  output tss_pkg::dp_status_t            status_o,
  output tss_pkg::out_item_t             out_data_o
);

  localparam int unsigned CW = $clog2(MAX_SCREEN);
  localparam int unsigned AW = $clog2(TEX_DEPTH);
  localparam int unsigned XW = ((AW > 17) ? AW : 17) + 1;
  localparam int unsigned IW = ((AW > 16) ? AW : 16) + 1;
  localparam logic [12:0] MaxScr = 13'(MAX_SCREEN);
  localparam logic [XW-1:0] DepthX = XW'(TEX_DEPTH);
  localparam logic [IW-1:0] DepthI = IW'(TEX_DEPTH);

  // Configuration registers.
  logic [10:0] scr_w_q, scr_h_q;
  logic [8:0]  tex_w_q, tex_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= 11'd640;
      scr_h_q <= 11'd480;
      tex_w_q <= 9'd256;
      tex_h_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (tss_pkg::cfg_e'(cfg_idx_i))
        tss_pkg::CFG_SCREEN_W: scr_w_q <= cfg_data_i;
        tss_pkg::CFG_SCREEN_H: scr_h_q <= cfg_data_i;
        tss_pkg::CFG_TEX_W:    tex_w_q <= cfg_data_i[8:0];
        tss_pkg::CFG_TEX_H:    tex_h_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Effective screen and texture sizes.
  logic [10:0] sw, sh;
  logic [8:0]  tw_n, th_n;
  assign sw   = ({2'b00, scr_w_q} > MaxScr) ? MaxScr[10:0] : scr_w_q;
  assign sh   = ({2'b00, scr_h_q} > MaxScr) ? MaxScr[10:0] : scr_h_q;
  assign tw_n = (tex_w_q == 9'd0) ? 9'd1 : tex_w_q;
  assign th_n = (tex_h_q == 9'd0) ? 9'd1 : tex_h_q;

  // Span state.
  logic signed [11:0] lx_q, ly_q;
  logic [15:0]        a_q [5];
  logic [15:0]        b_q [5];
  logic signed [12:0] len_q;
  logic [CW-1:0]      first_q, final_q, col_q;
  logic               active_q;
  logic [15:0]        in_ch [5];

  assign in_ch[0] = in_data_i.red;
  assign in_ch[1] = in_data_i.green;
  assign in_ch[2] = in_data_i.blue;
  assign in_ch[3] = in_data_i.tex_s;
  assign in_ch[4] = in_data_i.tex_t;

  // Clipping of a new span against the screen.
  logic signed [12:0] lx13, ly13, rx13, sw13, sh13, x0, x1;
  logic               reject;

  always_comb begin
    lx13   = {lx_q[11], lx_q};
    ly13   = {ly_q[11], ly_q};
    rx13   = {in_data_i.x[11], in_data_i.x};
    sw13   = $signed({2'b00, sw});
    sh13   = $signed({2'b00, sh});
    x0     = (lx13 < 13'sd0) ? 13'sd0 : lx13;
    x1     = (rx13 >= sw13) ? (sw13 - 13'sd1) : rx13;
    reject = (ly13 < 13'sd0) || (ly13 >= sh13) || (x0 >= sw13) || (x1 < 13'sd0) ||
             (x0 > x1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q     <= '0;
      ly_q     <= '0;
      len_q    <= '0;
      first_q  <= '0;
      final_q  <= '0;
      col_q    <= '0;
      active_q <= 1'b0;
      for (int c = 0; c < 5; c++) begin
        a_q[c] <= '0;
        b_q[c] <= '0;
      end
    end else begin
      if (cmd_i.ld_left) begin
        lx_q     <= in_data_i.x;
        ly_q     <= in_data_i.y;
        active_q <= 1'b0;
        for (int c = 0; c < 5; c++) a_q[c] <= in_ch[c];
      end
      if (cmd_i.ld_right) begin
        len_q    <= rx13 - lx13;
        active_q <= !reject;
        for (int c = 0; c < 5; c++) b_q[c] <= in_ch[c];
        if (!reject) begin
          first_q <= x0[CW-1:0];
          final_q <= x1[CW-1:0];
          col_q   <= x0[CW-1:0];
        end
      end
      // Step to the next column, or close the span after its last pixel.
      if (cmd_i.emit) begin
        if (col_q == final_q) active_q <= 1'b0;
        else col_q <= col_q + CW'(1);
      end
    end
  end

  // Restoring divider for the weight: one quotient bit a cycle.
  logic        len_pos;
  logic [12:0] dv13, diff13, rem_q;
  logic [13:0] rem_sh;
  logic        rem_ge;
  logic        q_hi_q;
  logic [15:0] q_lo_q;
  logic [4:0]  cnt_q;

  assign len_pos = !len_q[12] && (len_q != 13'sd0);
  assign dv13    = {1'b0, len_q[11:0]};
  assign diff13  = 13'(col_q - first_q);
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_ge  = rem_sh >= {1'b0, dv13};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_load) begin
      cnt_q <= len_pos ? 5'd16 : 5'd0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      q_lo_q <= '0;
      if (len_pos && (diff13 >= dv13)) begin
        rem_q  <= diff13 - dv13;
        q_hi_q <= 1'b1;
      end else begin
        rem_q  <= diff13;
        q_hi_q <= 1'b0;
      end
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? 13'(rem_sh - {1'b0, dv13}) : rem_sh[12:0];
      q_lo_q <= {q_lo_q[14:0], rem_ge};
    end
  end

  assign status_o.div_done    = (cnt_q == 5'd0);
  assign status_o.span_active = active_q;

  // Interpolation: v = a + (w * (b - a)) >>> 16, one multiplier per lane.
  logic [15:0]        w;
  logic signed [16:0] dlt [5];
  logic signed [33:0] prod_q [5];
  logic signed [17:0] mix_sum [5];
  logic [15:0]        v_q [5];
  logic [21:0]        pix_mul;
  logic [19:0]        pix_q;

  assign w = q_hi_q ? 16'hFFFF : q_lo_q;

  always_comb begin
    for (int c = 0; c < 5; c++) begin
      dlt[c]     = $signed({1'b0, b_q[c]}) - $signed({1'b0, a_q[c]});
      mix_sum[c] = $signed({2'b00, a_q[c]}) + $signed(prod_q[c][33:16]);
    end
  end

  assign pix_mul = 22'(ly_q[10:0]) * 22'(sw);

  always_ff @(posedge clk_i) begin
    if (cmd_i.lerp) begin
      for (int c = 0; c < 5; c++) prod_q[c] <= $signed({1'b0, w}) * dlt[c];
    end
    if (cmd_i.mix) begin
      for (int c = 0; c < 5; c++) v_q[c] <= mix_sum[c][15:0];
      pix_q <= 20'(pix_mul + 22'(col_q));
    end
  end

  // Texel coordinates, scaled and clamped to the texture size.
  logic [24:0] s_prod, t_prod;
  logic [8:0]  s_q, t_q;
  logic [17:0] addr18;
  logic [XW-1:0] addr_q;
  logic        addr_ok_q, rd_ok_q;

  assign s_prod = 25'(v_q[3]) * 25'(tw_n);
  assign t_prod = 25'(v_q[4]) * 25'(th_n);
  assign addr18 = 18'(t_q) * 18'(tw_n) + 18'(s_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.texc) begin
      s_q <= (s_prod[24:16] > tw_n - 9'd1) ? tw_n - 9'd1 : s_prod[24:16];
      t_q <= (t_prod[24:16] > th_n - 9'd1) ? th_n - 9'd1 : t_prod[24:16];
    end
    if (cmd_i.addr) begin
      addr_q    <= XW'(addr18);
      addr_ok_q <= XW'(addr18) < DepthX;
    end
  end

  // Texel store, one write or one registered read per cycle.
  logic [23:0] tex_mem [TEX_DEPTH];
  logic [23:0] tex_q;
  logic [IW-1:0] wr_idx;

  assign wr_idx = IW'(in_data_i.texel_index);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tex_wr && (wr_idx < DepthI)) begin
      tex_mem[wr_idx[AW-1:0]] <= in_data_i.texel_value;
    end
    if (cmd_i.read) begin
      tex_q   <= tex_mem[addr_q[AW-1:0]];
      rd_ok_q <= addr_ok_q;
    end
  end

  // Color modulation; byte * texel / 255 uses the exact 16-bit shortcut.
  logic [23:0] tex_eff;
  logic [15:0] cprod_q [3];
  logic [16:0] fix [3];

  assign tex_eff = rd_ok_q ? tex_q : 24'd0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fix[i] = 17'(cprod_q[i]) + 17'(cprod_q[i][15:8]) + 17'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      cprod_q[0] <= 16'(v_q[0][15:8]) * 16'(tex_eff[23:16]);
      cprod_q[1] <= 16'(v_q[1][15:8]) * 16'(tex_eff[15:8]);
      cprod_q[2] <= 16'(v_q[2][15:8]) * 16'(tex_eff[7:0]);
    end
    if (cmd_i.emit) begin
      out_data_o.pixel_index <= pix_q;
      out_data_o.pixel_color <= {fix[0][15:8], fix[1][15:8], fix[2][15:8]};
      out_data_o.span_last   <= (col_q == final_q);
    end
  end

endmodule

// File: rtl/core/tss_ctrl.sv
// ----------------------------------------------------------------------------
// Textured span shader controller
// Sequences each input word through the datapath and owns the output
// word's valid flag.
// ----------------------------------------------------------------------------
module tss_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tss_pkg::op_e         op_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tss_pkg::dp_cmd_t     cmd_o,
  input  tss_pkg::dp_status_t  status_i
);

  tss_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tss_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == tss_pkg::S_IDLE);
    case (state_q)
      tss_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            tss_pkg::OP_TEXEL: cmd_o.tex_wr   = 1'b1;
            tss_pkg::OP_LEFT:  cmd_o.ld_left  = 1'b1;
            tss_pkg::OP_RIGHT: cmd_o.ld_right = 1'b1;
            tss_pkg::OP_TICK: begin
              if (status_i.span_active) begin
                cmd_o.div_load = 1'b1;
                state_d        = tss_pkg::S_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      tss_pkg::S_DIV: begin
        if (status_i.div_done) state_d = tss_pkg::S_LERP;
        else cmd_o.div_step = 1'b1;
      end
      tss_pkg::S_LERP: begin
        cmd_o.lerp = 1'b1;
        state_d    = tss_pkg::S_MIX;
      end
      tss_pkg::S_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = tss_pkg::S_TEXC;
      end
      tss_pkg::S_TEXC: begin
        cmd_o.texc = 1'b1;
        state_d    = tss_pkg::S_ADDR;
      end
      tss_pkg::S_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d    = tss_pkg::S_READ;
      end
      tss_pkg::S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = tss_pkg::S_PROD;
      end
      tss_pkg::S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = tss_pkg::S_OUT;
      end
      tss_pkg::S_OUT: begin
        // Load the output register once it is empty or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = tss_pkg::S_IDLE;
        end
      end
      default: state_d = tss_pkg::S_IDLE;
    endcase
  end

  // Output valid: set on a new word, cleared when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  // A new output word appears only from the output state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == tss_pkg::S_OUT))
    else $error("output word raised outside the output state");

  // A tick on an active span starts the divider.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tss_pkg::S_IDLE && in_valid_i && op_i == tss_pkg::OP_TICK &&
     status_i.span_active) |=> (state_q == tss_pkg::S_DIV))
    else $error("tick on an active span did not start the divider");

  // The divider state is held until the quotient is complete.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tss_pkg::S_DIV && !status_i.div_done) |=> (state_q == tss_pkg::S_DIV))
    else $error("divider state left before the quotient was complete");

endmodule

// File: rtl/core/textured_span_shader.sv
// A pixel tick on an active span runs the bit-serial divider until the quotient
// is complete (no steps on a zero length), then lerp, mix, texel coordinate,
// address, read, product and an output step that waits for a free output word.
// Input waits until then; texel writes, endpoints and idle ticks stay in idle.
// Reset clears the span, the configuration to 640x480 and 256x256 texels;
// the texel store holds no defined data until written.
// ----------------------------------------------------------------------------
// Textured span shader
// Gouraud shaded, texture modulated fill of one clipped scanline span.
// ----------------------------------------------------------------------------
module textured_span_shader #(
  parameter int unsigned MAX_SCREEN = tss_pkg::MaxScreenDef,
  parameter int unsigned TEX_DEPTH  = tss_pkg::TexDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [tss_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tss_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tss_pkg::out_item_t            out_data_o
);

  tss_pkg::dp_cmd_t    cmd;
  tss_pkg::dp_status_t status;

  // Sequencer.
  tss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (in_data_i.op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Arithmetic and storage.
  tss_datapath #(
    .MAX_SCREEN (MAX_SCREEN),
    .TEX_DEPTH  (TEX_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// File: tb/tb_textured_span_shader.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Textured span shader testbench
// Drives texel loads, span endpoints and pixel ticks through the valid/ready
// input port, predicts every shaded pixel word and checks each output word
// against the oldest prediction, under several screen and texture sizes.
// ----------------------------------------------------------------------------
module tb_textured_span_shader;

  localparam int unsigned MaxScreen = 1024;
  localparam int unsigned TexDepth  = 65536;
  localparam int unsigned SettleCyc = 40;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned CfgW      = tss_pkg::CfgDataW;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [1:0]          cfg_idx;
  logic [CfgW-1:0]     cfg_data;
  logic                in_valid;
  logic                in_ready;
  tss_pkg::in_item_t   in_data;
  logic                out_valid;
  logic                out_ready;
  tss_pkg::out_item_t  out_data;

  textured_span_shader i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // Shadow state of the shader.
  logic [23:0]    texel_mem [int unsigned];
  int unsigned    scr_w, scr_h, tex_w, tex_h;
  int             left_x, left_y, span_len;
  int unsigned    left_rgb [3];
  int unsigned    right_rgb [3];
  int unsigned    left_st [2];
  int unsigned    right_st [2];
  int unsigned    first_col, final_col, cur_col;
  bit             span_on;

  tss_pkg::out_item_t pixel_q [$];
  int             fail_cnt;
  int unsigned    idle_cyc;
  int unsigned    burst_left;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_dim(int unsigned v);
    return (v > MaxScreen) ? MaxScreen : v;
  endfunction

  function automatic int unsigned blend(int unsigned w, int unsigned a, int unsigned b);
    longint unsigned acc;
    acc = longint'(w) * b + longint'(65536 - w) * a;
    return int'(acc >> 16);
  endfunction

  function automatic int unsigned tex_scale(int unsigned v, int unsigned size);
    int unsigned n;
    int unsigned c;
    n = (size == 0) ? 1 : size;
    c = int'((longint'(v) * n) >> 16);
    return (c > n - 1) ? n - 1 : c;
  endfunction

  // Interpolation weight of the current column.
  function automatic int unsigned col_weight();
    longint unsigned q;
    if (span_len <= 0) return 0;
    q = (longint'(cur_col - first_col) << 16) / longint'(span_len);
    return (q > 65535) ? 65535 : int'(q);
  endfunction

  // Texel address that the next tick of the current span reads.
  function automatic int unsigned next_texel_addr();
    int unsigned w;
    int unsigned s;
    int unsigned t;
    w = col_weight();
    s = tex_scale(blend(w, left_st[0], right_st[0]), tex_w);
    t = tex_scale(blend(w, left_st[1], right_st[1]), tex_h);
    return t * ((tex_w == 0) ? 1 : tex_w) + s;
  endfunction

  // Updates the shadow state for one accepted word and queues its pixel.
  task automatic shade_predict(input tss_pkg::in_item_t w);
    int unsigned sw;
    int unsigned sh;
    int          rx;
    int          x0;
    int          x1;
    int unsigned wt;
    int unsigned addr;
    int unsigned texel;
    int unsigned chan;
    int unsigned tb;
    tss_pkg::out_item_t px;
    sw = eff_dim(scr_w);
    sh = eff_dim(scr_h);
    case (w.op)
      tss_pkg::OP_TEXEL: begin
        texel_mem[32'(w.texel_index)] = w.texel_value;
      end
      tss_pkg::OP_LEFT: begin
        left_x = int'(w.x);
        left_y = int'(w.y);
        left_rgb = '{32'(w.red), 32'(w.green), 32'(w.blue)};
        left_st = '{32'(w.tex_s), 32'(w.tex_t)};
        span_on = 1'b0;
      end
      tss_pkg::OP_RIGHT: begin
        rx = int'(w.x);
        x0 = (left_x < 0) ? 0 : left_x;
        x1 = (rx >= int'(sw)) ? int'(sw) - 1 : rx;
        right_rgb = '{32'(w.red), 32'(w.green), 32'(w.blue)};
        right_st = '{32'(w.tex_s), 32'(w.tex_t)};
        span_len = rx - left_x;
        span_on = 1'b0;
        if (!(left_y < 0 || left_y >= int'(sh)) &&
            !(x0 >= int'(sw) || x1 < 0 || x0 > x1)) begin
          first_col = x0;
          final_col = x1;
          cur_col = x0;
          span_on = 1'b1;
        end
      end
      tss_pkg::OP_TICK: begin
        if (span_on) begin
          wt = col_weight();
          addr = next_texel_addr();
          texel = (addr < TexDepth && texel_mem.exists(addr)) ? 32'(texel_mem[addr]) : 0;
          px.pixel_color = '0;
          for (int i = 0; i < 3; i++) begin
            chan = blend(wt, left_rgb[i], right_rgb[i]) >> 8;
            tb = (texel >> (16 - 8 * i)) & 32'hFF;
            px.pixel_color = {px.pixel_color[15:0], 8'((chan * tb) / 255)};
          end
          px.pixel_index = 20'(longint'(unsigned'(left_y)) * sw + cur_col);
          px.span_last = (cur_col == final_col);
          pixel_q.push_back(px);
          if (px.span_last) span_on = 1'b0;
          else cur_col++;
        end
      end
      default: ;
    endcase
  endtask

  // Sends one word: bursts of back-to-back words separated by idle gaps.
  task automatic send_word(input tss_pkg::in_item_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    shade_predict(w);
  endtask

  task automatic send_texel(input int unsigned idx, input logic [23:0] val);
    tss_pkg::in_item_t w;
    w = '0;
    w.op = tss_pkg::OP_TEXEL;
    w.texel_index = 16'(idx);
    w.texel_value = val;
    send_word(w);
  endtask

  task automatic send_end(input tss_pkg::op_e op, input int x, input int y);
    tss_pkg::in_item_t w;
    w = '0;
    w.op = op;
    w.x = 12'(x);
    w.y = 12'(y);
    w.red = 16'($urandom);
    w.green = 16'($urandom);
    w.blue = 16'($urandom);
    w.tex_s = 16'($urandom);
    w.tex_t = 16'($urandom);
    w.texel_index = 16'($urandom);
    w.texel_value = 24'($urandom);
    send_word(w);
  endtask

  // A tick; loads the texel it will read first, so no unwritten entry is read.
  task automatic send_tick();
    tss_pkg::in_item_t w;
    int unsigned       addr;
    if (span_on) begin
      addr = next_texel_addr();
      if (addr < TexDepth && !texel_mem.exists(addr)) send_texel(addr, 24'($urandom));
    end
    w = tss_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    w.op = tss_pkg::OP_TICK;
    send_word(w);
  endtask

  // Waits until the shader is idle with nothing pending.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic set_cfg(input tss_pkg::cfg_e idx, input int unsigned val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CfgW'(val);
    @(negedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      tss_pkg::CFG_SCREEN_W: scr_w = val & 32'h7FF;
      tss_pkg::CFG_SCREEN_H: scr_h = val & 32'h7FF;
      tss_pkg::CFG_TEX_W:    tex_w = val & 32'h1FF;
      tss_pkg::CFG_TEX_H:    tex_h = val & 32'h1FF;
      default: ;
    endcase
  endtask

  task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                           input int unsigned tw, input int unsigned th);
    drain();
    set_cfg(tss_pkg::CFG_SCREEN_W, sw);
    set_cfg(tss_pkg::CFG_SCREEN_H, sh);
    set_cfg(tss_pkg::CFG_TEX_W, tw);
    set_cfg(tss_pkg::CFG_TEX_H, th);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_tick();
  endtask

  // Edge cases of span setup, clipping and ticking.
  task automatic test_directed();
    int sw;
    sw = int'(eff_dim(scr_w));
    send_texel(0, 24'hFFFFFF);
    send_texel(16'hFFFF, 24'h000000);
    run_ticks(1);                       // no span yet
    send_end(tss_pkg::OP_LEFT, -2048, 3);   // left end clamped, right end clamped
    send_end(tss_pkg::OP_RIGHT, 2047, 0);
    run_ticks(3);
    send_end(tss_pkg::OP_LEFT, sw - 3, 5);
    send_end(tss_pkg::OP_RIGHT, sw + 40, 0);
    run_ticks(4);                       // three pixels and one idle tick
    send_end(tss_pkg::OP_LEFT, 7, 2);       // zero length span
    send_end(tss_pkg::OP_RIGHT, 7, 0);
    run_ticks(1);
    send_end(tss_pkg::OP_LEFT, 9, -1);      // row above the screen
    send_end(tss_pkg::OP_RIGHT, 12, 0);
    run_ticks(1);
    send_end(tss_pkg::OP_LEFT, 9, 2047);    // row below the screen
    send_end(tss_pkg::OP_RIGHT, 12, 0);
    send_end(tss_pkg::OP_LEFT, 20, 1);      // reversed ends
    send_end(tss_pkg::OP_RIGHT, 10, 0);
    run_ticks(1);
    send_end(tss_pkg::OP_LEFT, -30, 1);     // wholly left of the screen
    send_end(tss_pkg::OP_RIGHT, -5, 0);
    send_end(tss_pkg::OP_LEFT, sw, 1);      // wholly right of the screen
    send_end(tss_pkg::OP_RIGHT, sw + 5, 0);
    run_ticks(1);
    send_end(tss_pkg::OP_LEFT, 0, 4);       // left endpoint cuts the span short
    send_end(tss_pkg::OP_RIGHT, 8, 0);
    run_ticks(2);
    send_end(tss_pkg::OP_LEFT, 1, 4);
    run_ticks(1);
  endtask

  // Mostly well-formed spans with random content, plus noise words.
  task automatic test_random(input int n_words);
    int                sw;
    int                sh;
    int                lx;
    int                len;
    int                n;
    tss_pkg::in_item_t w;
    sw = int'(eff_dim(scr_w));
    sh = int'(eff_dim(scr_h));
    n = 0;
    while (n < n_words) begin
      if ($urandom_range(0, 5) == 0) begin
        w = tss_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if (w.op == tss_pkg::OP_TICK) send_tick();
        else send_word(w);
        n++;
      end else begin
        lx = int'($urandom_range(0, sw + 4)) - 4;
        len = int'($urandom_range(0, 10));
        case ($urandom_range(0, 9))
          0: len = -int'($urandom_range(1, 5));
          1: len = int'($urandom_range(100, 3000));
          default: ;
        endcase
        send_end(tss_pkg::OP_LEFT, lx,
                 ($urandom_range(0, 9) == 0) ? -1 : int'($urandom_range(0, sh)));
        send_end(tss_pkg::OP_RIGHT, lx + len, int'($urandom));
        n += 2;
        len = (len < 0) ? 1 : ((len > 14) ? 14 : len);
        len = len + int'($urandom_range(0, 2)) - 1;
        run_ticks((len < 0) ? 0 : len);
        n += (len < 0) ? 0 : len;
      end
    end
  endtask

  // Receiver: ready follows one of four random patterns, picked anew after each run.
  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      mode = int'($urandom_range(0, 3));
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Checks each accepted pixel word against the oldest prediction.
  always @(posedge clk) begin
    tss_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel word %h", out_data);
        fail_cnt++;
      end else begin
        want = pixel_q.pop_front();
        if (out_data.pixel_index !== want.pixel_index) begin
          $error("pixel_index: expected %0d, actual %0d",
                 want.pixel_index, out_data.pixel_index);
          fail_cnt++;
        end
        if (out_data.pixel_color !== want.pixel_color) begin
          $error("pixel_color: expected %h, actual %h",
                 want.pixel_color, out_data.pixel_color);
          fail_cnt++;
        end
        if (out_data.span_last !== want.span_last) begin
          $error("span_last: expected %0b, actual %0b",
                 want.span_last, out_data.span_last);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  // Test sequence.
  initial begin
    cfg_we = 1'b0;
    cfg_idx = tss_pkg::CFG_SCREEN_W;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    fail_cnt = 0;
    idle_cyc = 0;
    burst_left = 0;
    scr_w = 640;
    scr_h = 480;
    tex_w = 256;
    tex_h = 256;
    left_x = 0;
    left_y = 0;
    span_len = 0;
    left_rgb = '{0, 0, 0};
    right_rgb = '{0, 0, 0};
    left_st = '{0, 0};
    right_st = '{0, 0};
    first_col = 0;
    final_col = 0;
    cur_col = 0;
    span_on = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(70);
    set_sizes(2047, 2047, 0, 0);        // oversized screen, zero texture
    test_directed();
    test_random(40);
    set_sizes(0, 0, 256, 256);          // zero screen rejects all spans
    test_random(20);
    set_sizes(1, 1, 1, 1);
    test_random(30);
    set_sizes(1024, 1024, 511, 9);
    test_random(50);
    set_sizes(33, 17, 5, 256);
    test_directed();
    test_random(50);
    set_sizes(640, 480, 256, 256);
    test_random(40);

    @(negedge clk);
    in_valid <= 1'b0;
    drain();
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
